// ----- rtl/bftm_pkg.sv -----
package bftm_pkg;

    localparam int PROG_DEPTH  = 4096;
    localparam int TAPE_DEPTH  = 4096;
    localparam int STACK_DEPTH = 64;
    localparam int CELL_BITS   = 32;

    localparam int PA_W = $clog2(PROG_DEPTH);
    localparam int PL_W = PA_W + 1;
    localparam int TP_W = $clog2(TAPE_DEPTH);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int SC_W = SA_W + 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CLOSE      = 3'd1;
    localparam logic [2:0] ERR_OPEN       = 3'd2;
    localparam logic [2:0] ERR_TAPE       = 3'd3;
    localparam logic [2:0] ERR_PROG_FULL  = 3'd4;
    localparam logic [2:0] ERR_STACK_FULL = 3'd5;

    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] prog_byte;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] error_code;
        logic       halted;
        logic       in_used;
        logic       out_valid;
        logic [7:0] out_char;
    } res_t;

endpackage

// ----- rtl/bftm_ram.sv -----
module bftm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- rtl/bftm_ctrl.sv -----
module bftm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    output logic           item_ready,
    input  bftm_pkg::item_t item,
    output logic           res_valid,
    input  logic           res_ready,
    output bftm_pkg::res_t res
);
    import bftm_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_EXEC     = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CHK = 3'd4;
    localparam logic [2:0] S_RESULT   = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [PL_W-1:0] ip_reg, ip_next;
    logic [PL_W-1:0] len_reg, len_next;
    logic [TP_W-1:0] tp_reg, tp_next;
    logic [SC_W-1:0] sc_reg, sc_next;
    logic            stop_reg, stop_next;
    logic            pend_reg, pend_next;
    logic [TP_W-1:0] clr_reg, clr_next;
    logic [PL_W-1:0] p_reg, p_next;
    logic [PL_W-1:0] dep_reg, dep_next;
    logic [7:0]      inb_reg, inb_next;
    res_t            res_reg, res_next;

    logic                 prog_en, prog_we;
    logic [PA_W-1:0]      prog_addr;
    logic [7:0]           prog_wd, prog_q;
    logic                 tape_en, tape_we;
    logic [TP_W-1:0]      tape_addr;
    logic [CELL_BITS-1:0] tape_wd, tape_q;
    logic                 stk_en, stk_we;
    logic [SA_W-1:0]      stk_addr;
    logic [PA_W-1:0]      stk_wd, stk_q;
    logic                 fin;
    logic [PL_W-1:0]      ip_inc, p_inc;
    logic                 cell_nz;
    logic [SC_W-1:0]      sc_dec;

    bftm_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog (
        .aclk(aclk), .en(prog_en), .we(prog_we), .addr(prog_addr),
        .wdata(prog_wd), .rdata(prog_q)
    );

    bftm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(CELL_BITS)) u_tape (
        .aclk(aclk), .en(tape_en), .we(tape_we), .addr(tape_addr),
        .wdata(tape_wd), .rdata(tape_q)
    );

    bftm_ram #(.DEPTH(STACK_DEPTH), .WIDTH(PA_W)) u_stack (
        .aclk(aclk), .en(stk_en), .we(stk_we), .addr(stk_addr),
        .wdata(stk_wd), .rdata(stk_q)
    );

    assign ip_inc    = ip_reg + 1'b1;
    assign p_inc     = p_reg + 1'b1;
    assign cell_nz   = (tape_q != '0);
    assign sc_dec    = sc_reg - 1'b1;
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        ip_next    = ip_reg;
        len_next   = len_reg;
        tp_next    = tp_reg;
        sc_next    = sc_reg;
        stop_next  = stop_reg;
        pend_next  = pend_reg;
        clr_next   = clr_reg;
        p_next     = p_reg;
        dep_next   = dep_reg;
        inb_next   = inb_reg;
        res_next   = res_reg;
        prog_en    = 1'b0;
        prog_we    = 1'b0;
        prog_addr  = ip_reg[PA_W-1:0];
        prog_wd    = item.prog_byte;
        tape_en    = 1'b0;
        tape_we    = 1'b0;
        tape_addr  = tp_reg;
        tape_wd    = '0;
        stk_en     = 1'b0;
        stk_we     = 1'b0;
        stk_addr   = sc_dec[SA_W-1:0];
        stk_wd     = ip_reg[PA_W-1:0];
        item_ready = 1'b0;
        res_valid  = 1'b0;
        fin        = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                tape_en   = 1'b1;
                tape_we   = 1'b1;
                tape_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == TP_W'(TAPE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    res_next        = '0;
                    res_next.halted = stop_reg;
                    state_next      = S_RESULT;
                    unique case (item.opcode)
                        OP_LOAD: begin
                            if (len_reg >= PL_W'(PROG_DEPTH)) begin
                                res_next.error_code = ERR_PROG_FULL;
                            end else begin
                                prog_en   = 1'b1;
                                prog_we   = 1'b1;
                                prog_addr = len_reg[PA_W-1:0];
                                len_next  = len_reg + 1'b1;
                            end
                        end
                        OP_START: begin
                            ip_next         = '0;
                            tp_next         = '0;
                            sc_next         = '0;
                            stop_next       = 1'b0;
                            res_next.halted = 1'b0;
                            pend_next       = 1'b1;
                        end
                        OP_STEP: begin
                            if (!stop_reg) begin
                                prog_en    = 1'b1;
                                tape_en    = 1'b1;
                                stk_en     = 1'b1;
                                inb_next   = item.in_byte;
                                state_next = S_EXEC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXEC: begin
                state_next = S_RESULT;
                if (ip_reg >= len_reg) begin
                    fin = 1'b1;
                end else begin
                    case (prog_q) inside
                        CH_LEFT: begin
                            if (tp_reg == '0) begin
                                stop_next           = 1'b1;
                                res_next.halted     = 1'b1;
                                res_next.error_code = ERR_TAPE;
                            end else begin
                                tp_next = tp_reg - 1'b1;
                                ip_next = ip_inc;
                                fin     = 1'b1;
                            end
                        end
                        CH_RIGHT: begin
                            if (tp_reg == TP_W'(TAPE_DEPTH - 1)) begin
                                stop_next           = 1'b1;
                                res_next.halted     = 1'b1;
                                res_next.error_code = ERR_TAPE;
                            end else begin
                                tp_next = tp_reg + 1'b1;
                                ip_next = ip_inc;
                                fin     = 1'b1;
                            end
                        end
                        CH_INC, CH_DEC, CH_IN: begin
                            tape_en = 1'b1;
                            tape_we = 1'b1;
                            if (prog_q == CH_INC) begin
                                tape_wd = tape_q + 1'b1;
                            end else if (prog_q == CH_DEC) begin
                                tape_wd = tape_q - 1'b1;
                            end else begin
                                tape_wd = {{(CELL_BITS - 8){inb_reg[7]}}, inb_reg};
                                res_next.in_used = 1'b1;
                            end
                            ip_next = ip_inc;
                            fin     = 1'b1;
                        end
                        CH_OUT: begin
                            res_next.out_valid = 1'b1;
                            res_next.out_char  = tape_q[7:0];
                            ip_next            = ip_inc;
                            fin                = 1'b1;
                        end
                        CH_OPEN: begin
                            if (cell_nz) begin
                                if (sc_reg == SC_W'(STACK_DEPTH)) begin
                                    stop_next           = 1'b1;
                                    res_next.halted     = 1'b1;
                                    res_next.error_code = ERR_STACK_FULL;
                                end else begin
                                    stk_en   = 1'b1;
                                    stk_we   = 1'b1;
                                    stk_addr = sc_reg[SA_W-1:0];
                                    sc_next  = sc_reg + 1'b1;
                                    ip_next  = ip_inc;
                                    fin      = 1'b1;
                                end
                            end else begin
                                p_next     = ip_reg;
                                dep_next   = PL_W'(1);
                                state_next = S_SCAN_RD;
                            end
                        end
                        CH_CLOSE: begin
                            if (sc_reg == '0) begin
                                stop_next           = 1'b1;
                                res_next.halted     = 1'b1;
                                res_next.error_code = ERR_CLOSE;
                            end else begin
                                if (cell_nz) begin
                                    ip_next = {1'b0, stk_q} + 1'b1;
                                end else begin
                                    sc_next = sc_dec;
                                    ip_next = ip_inc;
                                end
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            ip_next = ip_inc;
                            fin     = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (p_inc >= len_reg) begin
                    ip_next             = len_reg;
                    stop_next           = 1'b1;
                    res_next.halted     = 1'b1;
                    res_next.error_code = ERR_OPEN;
                    state_next          = S_RESULT;
                end else begin
                    prog_en    = 1'b1;
                    prog_addr  = p_inc[PA_W-1:0];
                    p_next     = p_inc;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                state_next = S_SCAN_RD;
                if (prog_q == CH_OPEN) begin
                    dep_next = dep_reg + 1'b1;
                end else if (prog_q == CH_CLOSE) begin
                    if (dep_reg == PL_W'(1)) begin
                        ip_next    = p_inc;
                        fin        = 1'b1;
                        state_next = S_RESULT;
                    end else begin
                        dep_next = dep_reg - 1'b1;
                    end
                end
            end
            S_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    pend_next  = 1'b0;
                    clr_next   = '0;
                    state_next = pend_reg ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin && (ip_next >= len_reg)) begin
            stop_next           = 1'b1;
            res_next.halted     = 1'b1;
            res_next.error_code = (sc_next != '0) ? ERR_OPEN : ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ip_reg    <= '0;
            len_reg   <= '0;
            tp_reg    <= '0;
            sc_reg    <= '0;
            stop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ip_reg    <= ip_next;
            len_reg   <= len_next;
            tp_reg    <= tp_next;
            sc_reg    <= sc_next;
            stop_reg  <= stop_next;
            pend_reg  <= pend_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg   <= p_next;
        dep_reg <= dep_next;
        inb_reg <= inb_next;
        res_reg <= res_next;
    end

endmodule

// ----- rtl/bf_tape_machine_step_top.sv -----
// a forward bracket skip scans the program byte by byte through S_SCAN_RD and S_SCAN_CHK
// throughput: one transaction at a time; the next is accepted once the result leaves the controller
// the result register lets a new transaction enter while a result waits on m_tready
// reset and every start sweep the tape to zero, one cell a cycle, with s_tready low
// reset is synchronous, active low on aresetn
module bf_tape_machine_step_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // prog_byte[7:0], in_byte[15:8]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic [5:0]  m_tuser    // out_valid[0], in_used[1], halted[2], error_code[5:3]
);
    import bftm_pkg::*;

    item_t item;
    res_t  res;
    res_t  out_reg;
    logic  res_valid, res_ready;
    logic  m_tvalid_reg;

    assign item.opcode    = s_tuser;
    assign item.prog_byte = s_tdata[7:0];
    assign item.in_byte   = s_tdata[15:8];

    bftm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .item_valid(s_tvalid), .item_ready(s_tready), .item(item),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.out_char;
    assign m_tuser  = {out_reg.error_code, out_reg.halted, out_reg.in_used, out_reg.out_valid};

endmodule

// ----- bench/bf_tape_machine_step_top_tb.sv -----
module bf_tape_machine_step_top_tb;
    import bftm_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [1:0] op;
        logic [7:0] pb;
        logic [7:0] ib;
        bit         typed;
        res_t       res;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // prog_byte[7:0], in_byte[15:8]
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_char[7:0]
    logic [5:0]  m_tuser;   // out_valid[0], in_used[1], halted[2], error_code[5:3]

    bf_tape_machine_step_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // machine state mirrored by the bench
    logic [7:0]           prog_mem [PROG_DEPTH];
    int                   prog_len;
    int                   pc;
    logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];
    int                   head;
    int                   loop_pcs [STACK_DEPTH];
    int                   depth_cnt;
    bit                   is_stopped;

    int   guard_blk [PROG_DEPTH];
    bit   sel_blk [128];
    int   nblk;
    res_t expected_res [$];
    row_t rows [$];
    int   fails, n_items, n_rand, n_runs, n_results, n_chars;
    int   err_seen [8];
    bit   quiet, in_rand;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("bf_tape_machine_step_top_tb NOT OK");
        $finish;
    end

    function automatic logic [2:0] end_run();
        is_stopped = 1;
        return (depth_cnt != 0) ? ERR_OPEN : ERR_NONE;
    endfunction

    function automatic res_t machine_step(logic [1:0] op, logic [7:0] pb, logic [7:0] ib);
        res_t                 r;
        logic [2:0]           err;
        logic [7:0]           insn;
        logic [CELL_BITS-1:0] cur_cell;
        bit                   adv;
        int                   d, p;
        r = '0;
        err = ERR_NONE;
        case (op)
            OP_LOAD: begin
                if (prog_len >= PROG_DEPTH) err = ERR_PROG_FULL;
                else begin
                    prog_mem[prog_len] = pb;
                    prog_len++;
                end
            end
            OP_START: begin
                for (int i = 0; i < TAPE_DEPTH; i++) tape_mem[i] = '0;
                pc = 0;
                head = 0;
                depth_cnt = 0;
                is_stopped = 0;
            end
            OP_STEP: if (!is_stopped) begin
                if (pc >= prog_len) err = end_run();
                else begin
                    adv = 1;
                    insn = prog_mem[pc];
                    cur_cell = tape_mem[head];
                    case (insn)
                        CH_LEFT: begin
                            if (head == 0) begin
                                is_stopped = 1; err = ERR_TAPE; adv = 0;
                            end else head--;
                        end
                        CH_RIGHT: begin
                            if (head == TAPE_DEPTH - 1) begin
                                is_stopped = 1; err = ERR_TAPE; adv = 0;
                            end else head++;
                        end
                        CH_INC: tape_mem[head] = cur_cell + 1'b1;
                        CH_DEC: tape_mem[head] = cur_cell - 1'b1;
                        CH_OUT: begin
                            r.out_valid = 1;
                            r.out_char = cur_cell[7:0];
                        end
                        CH_IN: begin
                            tape_mem[head] = {{(CELL_BITS-8){ib[7]}}, ib};
                            r.in_used = 1;
                        end
                        CH_OPEN: begin
                            if (cur_cell != 0) begin
                                if (depth_cnt >= STACK_DEPTH) begin
                                    is_stopped = 1; err = ERR_STACK_FULL; adv = 0;
                                end else begin
                                    loop_pcs[depth_cnt] = pc;
                                    depth_cnt++;
                                end
                            end else begin
                                d = 1;
                                p = pc;
                                while (d != 0) begin
                                    p++;
                                    if (p >= prog_len) begin
                                        pc = prog_len; is_stopped = 1; err = ERR_OPEN;
                                        adv = 0; d = 0;
                                    end else if (prog_mem[p] == CH_OPEN) d++;
                                    else if (prog_mem[p] == CH_CLOSE) d--;
                                end
                                if (adv) pc = p;
                            end
                        end
                        CH_CLOSE: begin
                            if (depth_cnt == 0) begin
                                is_stopped = 1; err = ERR_CLOSE; adv = 0;
                            end else if (cur_cell != 0) pc = loop_pcs[depth_cnt-1];
                            else depth_cnt--;
                        end
                        default: ;
                    endcase
                    if (adv) begin
                        pc++;
                        if (pc >= prog_len) err = end_run();
                    end
                end
            end
            default: ;
        endcase
        r.halted = is_stopped;
        r.error_code = err;
        return r;
    endfunction

    function automatic logic [7:0] rnd_in();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h80;
            2: return 8'h7F;
            3: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send(logic [1:0] op, logic [7:0] pb, logic [7:0] ib, bit typed, res_t tres);
        res_t r;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {ib, pb};
        do @(posedge aclk); while (!s_tready);
        r = machine_step(op, pb, ib);
        expected_res.insert(expected_res.size(), typed ? tres : r);
        n_items++;
        if (in_rand) n_rand++;
    endtask

    task automatic add_row(row_t w);
        rows.insert(rows.size(), w);
    endtask

    task automatic add_block(string s);
        for (int i = 0; i < s.len(); i++) begin
            if (i == 0) guard_blk[prog_len] = nblk;
            send(OP_LOAD, s[i], rnd_in(), 0, '0);
        end
        nblk++;
    endtask

    function automatic string gen_block();
        string s;
        int    depth;
        s = ",[->";
        depth = 0;
        repeat ($urandom_range(3, 20)) begin
            case ($urandom_range(0, 9))
                0: s = {s, "+"};
                1, 9: s = {s, "-"};
                2: s = {s, ">"};
                3: s = {s, "<"};
                4: s = {s, "."};
                5: s = {s, ","};
                6: begin
                    if (depth < 3) begin
                        s = {s, "[-"}; depth++;
                    end else s = {s, "+"};
                end
                7: begin
                    if (depth > 0) begin
                        s = {s, "]"}; depth--;
                    end else s = {s, "."};
                end
                default: s = {s, "a"};
            endcase
        end
        repeat (depth) s = {s, "]"};
        return {s, "<]"};
    endfunction

    task automatic do_run(int cap);
        int         steps;
        logic [7:0] ib;
        send(OP_START, rnd_in(), rnd_in(), 0, '0);
        n_runs++;
        steps = 0;
        while (!is_stopped && steps < cap) begin
            if ($urandom_range(0, 29) == 0) send(OP_NONE, rnd_in(), rnd_in(), 0, '0);
            if ($urandom_range(0, 39) == 0)
                send(OP_LOAD, 8'h61 + 8'($urandom_range(0, 20)), rnd_in(), 0, '0);
            if (prog_len - pc <= 1 && prog_len < 3000 && $urandom_range(0, 3) == 0)
                send(OP_LOAD, CH_OUT, rnd_in(), 0, '0);
            ib = rnd_in();
            if (pc < prog_len && prog_mem[pc] == CH_IN && guard_blk[pc] >= 0)
                ib = sel_blk[guard_blk[pc]] ? 8'd1 : 8'd0;
            send(OP_STEP, rnd_in(), ib, 0, '0);
            steps++;
        end
    endtask

    function automatic row_t mk(logic [1:0] op, logic [7:0] pb, logic [7:0] ib, bit typed,
                                logic [2:0] err, bit halt, bit used);
        row_t w;
        w.op = op;
        w.pb = pb;
        w.ib = ib;
        w.typed = typed;
        w.res = '0;
        w.res.error_code = err;
        w.res.halted = halt;
        w.res.in_used = used;
        return w;
    endfunction

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            err_seen[m_tuser[5:3]]++;
            if (m_tuser[0]) n_chars++;
            if (expected_res.size() == 0) begin
                $error("result with nothing expected: tuser %h tdata %h", m_tuser, m_tdata);
                fails++;
            end else begin
                res_t w;
                w = expected_res.pop_front();
                if (m_tuser[0] !== w.out_valid) begin
                    $error("out_valid expected %0d actual %0d", w.out_valid, m_tuser[0]);
                    fails++;
                end
                if (m_tdata !== w.out_char) begin
                    $error("out_char expected %h actual %h", w.out_char, m_tdata);
                    fails++;
                end
                if (m_tuser[1] !== w.in_used) begin
                    $error("in_used expected %0d actual %0d", w.in_used, m_tuser[1]);
                    fails++;
                end
                if (m_tuser[2] !== w.halted) begin
                    $error("halted expected %0d actual %0d", w.halted, m_tuser[2]);
                    fails++;
                end
                if (m_tuser[5:3] !== w.error_code) begin
                    $error("error_code expected %0d actual %0d", w.error_code, m_tuser[5:3]);
                    fails++;
                end
            end
        end
    end

    // receiver with random stalls and one long hold
    initial begin
        bit held;
        held = 0;
        m_tready = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            if (!held && n_results >= 40) begin
                held = 1;
                m_tready <= 0;
                repeat (300) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    initial begin
        int blk_arith, blk_stack;
        int wait_cnt;
        string s;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = OP_NONE;
        prog_len = 0; pc = 0; head = 0; depth_cnt = 0; is_stopped = 0;
        for (int i = 0; i < TAPE_DEPTH; i++) tape_mem[i] = '0;
        for (int i = 0; i < PROG_DEPTH; i++) guard_blk[i] = -1;
        nblk = 0; fails = 0; n_items = 0; n_rand = 0; n_runs = 0;
        quiet = 0; in_rand = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // directed: empty program, unused opcode, left tape bound, stopped steps, skip
        add_row(mk(OP_STEP,  8'h00, 8'hFF, 1, ERR_NONE, 1, 0));
        add_row(mk(OP_NONE,  8'hFF, 8'hFF, 1, ERR_NONE, 1, 0));
        add_row(mk(OP_START, 8'h00, 8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_NONE,  8'h00, 8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_LOAD,  CH_IN,    8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_LOAD,  CH_OPEN,  8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_LOAD,  CH_DEC,   8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_LOAD,  CH_LEFT,  8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_LOAD,  CH_CLOSE, 8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_STEP,  8'h00, 8'h01, 1, ERR_NONE, 0, 1));
        add_row(mk(OP_STEP,  8'h00, 8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_STEP,  8'h00, 8'h00, 1, ERR_NONE, 0, 0));
        add_row(mk(OP_STEP,  8'h00, 8'h00, 1, ERR_TAPE, 1, 0));
        add_row(mk(OP_STEP,  8'h00, 8'h00, 1, ERR_NONE, 1, 0));
        add_row(mk(OP_START, 8'h00, 8'h00, 0, ERR_NONE, 0, 0));
        add_row(mk(OP_STEP,  8'h00, 8'h00, 0, ERR_NONE, 0, 0));
        add_row(mk(OP_STEP,  8'h00, 8'h00, 0, ERR_NONE, 0, 0));
        add_row(mk(OP_STEP,  8'h00, 8'hFF, 0, ERR_NONE, 0, 0));
        guard_blk[0] = 0;
        nblk = 1;
        foreach (rows[i]) send(rows[i].op, rows[i].pb, rows[i].ib, rows[i].typed, rows[i].res);

        // guarded blocks: a ',' reading 1 enters the block, 0 skips it
        blk_arith = nblk;
        add_block(",[->,.+.-.,.-.<]");
        blk_stack = nblk;
        s = ",[->+";
        repeat (STACK_DEPTH + 1) s = {s, "["};
        repeat (STACK_DEPTH + 1) s = {s, "]"};
        add_block({s, "<]"});
        repeat (15) add_block(gen_block());

        foreach (sel_blk[k]) sel_blk[k] = 0;
        sel_blk[blk_arith] = 1;
        repeat (4) do_run(300);
        sel_blk[blk_arith] = 0;
        sel_blk[blk_stack] = 1;
        do_run(600);
        sel_blk[blk_stack] = 0;

        in_rand = 1;
        while (n_rand < 800) begin
            for (int k = 0; k < nblk; k++) begin
                if (k == 0 || k == blk_stack) sel_blk[k] = ($urandom_range(0, 9) == 0);
                else sel_blk[k] = ($urandom_range(0, 3) == 0);
            end
            do_run($urandom_range(40, 200));
        end
        in_rand = 0;

        // unmatched brackets at the program end, then steps while stopped
        quiet = 1;
        foreach (sel_blk[k]) sel_blk[k] = 0;
        send(OP_LOAD, CH_OPEN, 8'h00, 0, '0);
        do_run(600);
        send(OP_LOAD, CH_CLOSE, 8'h00, 0, '0);
        send(OP_LOAD, CH_CLOSE, 8'h00, 0, '0);
        do_run(600);
        repeat (3) send(OP_STEP, 8'h00, rnd_in(), 0, '0);
        s_tvalid <= 0;

        wait_cnt = 0;
        while (expected_res.size() != 0 && wait_cnt < 200000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (20) @(posedge aclk);
        if (expected_res.size() != 0) begin
            $error("%0d results never arrived", expected_res.size());
            fails++;
        end
        $display("%0d transactions in %0d runs, %0d results, %0d characters output",
                 n_items, n_runs, n_results, n_chars);
        $display("error codes seen 1..5: %0d %0d %0d %0d %0d",
                 err_seen[1], err_seen[2], err_seen[3], err_seen[4], err_seen[5]);
        if (fails == 0) $display("bf_tape_machine_step_top_tb OK");
        else $display("bf_tape_machine_step_top_tb NOT OK");
        $finish;
    end

endmodule
